// ----- src/parity_steered_deque_assert.svh -----
// Assertion macros used by the verification checker of the deque.
`ifndef PARITY_STEERED_DEQUE_ASSERT_SVH
`define PARITY_STEERED_DEQUE_ASSERT_SVH

// Concurrent assertion that is switched off while reset is held.
`define PSDQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent assertion that also runs during reset.
`define PSDQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- src/psdq_pkg.sv -----
package psdq_pkg;

    // Result status codes.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_SHORT = 2'd2;

    // Operation codes carried by an input item.
    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_PARITY = 2'd1;
    localparam logic [1:0] MODE_RECENT = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Sequencer step addresses.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] SP_FETCH = 3'd0;
    localparam logic [STEP_W-1:0] SP_PUSH  = 3'd1;
    localparam logic [STEP_W-1:0] SP_PPOP  = 3'd2;
    localparam logic [STEP_W-1:0] SP_RCHK  = 3'd3;
    localparam logic [STEP_W-1:0] SP_RREAD = 3'd4;
    localparam logic [STEP_W-1:0] SP_RPOP  = 3'd5;
    localparam logic [STEP_W-1:0] SP_DONE  = 3'd6;

    // Datapath operations selected by a control word.
    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_LATCH = 3'd1;
    localparam logic [2:0] OP_PUSH  = 3'd2;
    localparam logic [2:0] OP_PPOP  = 3'd3;
    localparam logic [2:0] OP_RCHK  = 3'd4;
    localparam logic [2:0] OP_RREAD = 3'd5;
    localparam logic [2:0] OP_RPOP  = 3'd6;
    localparam logic [2:0] OP_DONE  = 3'd7;

    // Next-step conditions.
    localparam logic [2:0] C_NEXT     = 3'd0;
    localparam logic [2:0] C_JUMP     = 3'd1;
    localparam logic [2:0] C_DISPATCH = 3'd2;
    localparam logic [2:0] C_LEFT0    = 3'd3;
    localparam logic [2:0] C_OUTFREE  = 3'd4;

    typedef struct packed {
        logic [2:0]        op;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    // The control program.
    function automatic t_ctrl ucode(input logic [STEP_W-1:0] step);
        t_ctrl w;
        unique case (step)
            SP_FETCH: w = '{op: OP_LATCH, cond: C_DISPATCH, target: SP_FETCH};
            SP_PUSH:  w = '{op: OP_PUSH,  cond: C_JUMP,     target: SP_DONE};
            SP_PPOP:  w = '{op: OP_PPOP,  cond: C_JUMP,     target: SP_DONE};
            SP_RCHK:  w = '{op: OP_RCHK,  cond: C_NEXT,     target: SP_FETCH};
            SP_RREAD: w = '{op: OP_RREAD, cond: C_LEFT0,    target: SP_DONE};
            SP_RPOP:  w = '{op: OP_RPOP,  cond: C_JUMP,     target: SP_RREAD};
            SP_DONE:  w = '{op: OP_DONE,  cond: C_OUTFREE,  target: SP_FETCH};
            default:  w = '{op: OP_NOP,   cond: C_JUMP,     target: SP_FETCH};
        endcase
        return w;
    endfunction

    // Entry step of the routine for each operation code.
    function automatic logic [STEP_W-1:0] mode_entry(input logic [1:0] mode);
        logic [STEP_W-1:0] s;
        unique case (mode)
            MODE_PUSH:   s = SP_PUSH;
            MODE_PARITY: s = SP_PPOP;
            MODE_RECENT: s = SP_RCHK;
            MODE_NONE:   s = SP_DONE;
        endcase
        return s;
    endfunction

endpackage

// ----- src/parity_steered_deque.sv -----
// Parity steered deque.
// Input channel: i_in_valid / o_in_stall carry one item (mode, value and the
// three pop counts). An item is taken on a rising edge where i_in_valid is high
// and o_in_stall is low. Output channel: o_out_valid / i_out_stall carry one
// result item (status and the total, even and odd counts) for every input item.
// The unused mode goes straight to the final step, a push or a parity pop
// runs one step before it, and a recency pop runs a check step and a tag
// read step, then a removal step and a further read step per entry. A new
// item can be taken in the cycle after its predecessor's result is loaded,
// so one item is finished before the next is taken. The control program
// runs one step per cycle unless it waits for an item or a free output
// register; each removal compares front and back tags read in the prior step.
// A synchronous low reset empties the deque, clears the sequence counter and
// parks the sequencer at its fetch step; the tag store is not cleared.
// When the receiver stalls, the result waits in the output register; the next
// item is still accepted and processed, and its result waits in the final step
// until the output register is free.
module parity_steered_deque
    import psdq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_value,
    input  logic [4:0]         i_even_pops,
    input  logic [4:0]         i_odd_pops,
    input  logic [4:0]         i_recent_pops,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [4:0]         o_total_held,
    output logic [4:0]         o_evens_held,
    output logic [4:0]         o_odds_held
);

    // Ring index, count and sum widths; the sum holds values below twice DEPTH.
    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = AW + 1;
    localparam int CMPW = (CW > 5) ? CW : 5;

    // Sequencer and datapath state.
    logic [STEP_W-1:0] r_step, n_step;
    logic [AW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_even, n_even;
    logic [CW-1:0]     r_odd, n_odd;
    logic [31:0]       r_seq, n_seq;
    logic [1:0]        r_status, n_status;
    logic              r_par, n_par;
    logic [4:0]        r_ne, n_ne;
    logic [4:0]        r_no, n_no;
    logic [4:0]        r_nr, n_nr;
    logic [4:0]        r_left, n_left;
    logic [31:0]       r_ftag, r_btag;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [1:0]        r_o_status, n_o_status;
    logic [4:0]        r_o_total, n_o_total;
    logic [4:0]        r_o_even, n_o_even;
    logic [4:0]        r_o_odd, n_o_odd;

    // Tag store, one entry per ring slot.
    logic [31:0]       r_tags [DEPTH];

    t_ctrl             w_ctrl;
    logic              w_accept;
    logic              w_out_free;
    logic [CW-1:0]     w_held;
    logic [AW-1:0]     w_back_slot;
    logic [AW-1:0]     w_push_slot;
    logic [AW-1:0]     w_front_dec;
    logic [AW-1:0]     w_front_inc;
    logic [AW-1:0]     w_front_ne;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [31:0]       w_wdata;

    // Reduce a sum below twice DEPTH to a ring slot.
    function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
        return r[AW-1:0];
    endfunction

    // Counts are reported in five bits.
    function automatic logic [4:0] cnt5(input logic [CW-1:0] x);
        logic [CMPW-1:0] e;
        e = CMPW'(x);
        return e[4:0];
    endfunction

    function automatic logic [CMPW-1:0] ext_c(input logic [CW-1:0] x);
        return CMPW'(x);
    endfunction

    function automatic logic [CMPW-1:0] ext_p(input logic [4:0] x);
        return CMPW'(x);
    endfunction

    assign w_ctrl      = ucode(r_step);
    assign o_in_stall  = (r_step != SP_FETCH);
    assign w_accept    = i_in_valid && (r_step == SP_FETCH);
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_held      = r_even + r_odd;

    // The back slot tag is only compared while at least one entry is held.
    assign w_back_slot = wrap(SW'(r_front) + SW'(w_held) - SW'(1));
    assign w_push_slot = wrap(SW'(r_front) + SW'(w_held));
    assign w_front_inc = wrap(SW'(r_front) + SW'(1));
    assign w_front_ne  = wrap(SW'(r_front) + SW'(r_ne));
    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);

    always_comb begin
        n_step      = r_step;
        n_front     = r_front;
        n_even      = r_even;
        n_odd       = r_odd;
        n_seq       = r_seq;
        n_status    = r_status;
        n_par       = r_par;
        n_ne        = r_ne;
        n_no        = r_no;
        n_nr        = r_nr;
        n_left      = r_left;
        n_o_status  = r_o_status;
        n_o_total   = r_o_total;
        n_o_even    = r_o_even;
        n_o_odd     = r_o_odd;
        n_out_valid = r_out_valid && i_out_stall;
        w_we        = 1'b0;
        w_waddr     = w_push_slot;
        w_wdata     = r_seq + 32'd1;

        unique case (w_ctrl.op)
            OP_LATCH: begin
                if (w_accept) begin
                    n_par    = i_value[0];
                    n_ne     = i_even_pops;
                    n_no     = i_odd_pops;
                    n_nr     = i_recent_pops;
                    n_status = ST_DONE;
                end
            end
            OP_PUSH: begin
                if (ext_c(w_held) >= CMPW'(DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    n_seq = r_seq + 32'd1;
                    w_we  = 1'b1;
                    if (!r_par) begin
                        // Evens enter at the front, one slot before it.
                        n_front = w_front_dec;
                        w_waddr = w_front_dec;
                        n_even  = r_even + CW'(1);
                    end else begin
                        n_odd   = r_odd + CW'(1);
                    end
                end
            end
            OP_PPOP: begin
                if (ext_p(r_ne) > ext_c(r_even) || ext_p(r_no) > ext_c(r_odd)) begin
                    n_status = ST_SHORT;
                end else begin
                    n_front = w_front_ne;
                    n_even  = r_even - CW'(r_ne);
                    n_odd   = r_odd - CW'(r_no);
                end
            end
            OP_RCHK: begin
                if (ext_p(r_nr) > ext_c(w_held)) begin
                    n_status = ST_SHORT;
                    n_left   = 5'd0;
                end else begin
                    n_left   = r_nr;
                end
            end
            OP_RPOP: begin
                n_left = r_left - 5'd1;
                // Held entries are all evens followed by all odds, so the
                // parity of an end entry follows from the counts.
                if (w_held == CW'(1) || r_ftag > r_btag) begin
                    n_front = w_front_inc;
                    if (r_even != '0) begin
                        n_even = r_even - CW'(1);
                    end else begin
                        n_odd  = r_odd - CW'(1);
                    end
                end else begin
                    if (r_odd != '0) begin
                        n_odd  = r_odd - CW'(1);
                    end else begin
                        n_even = r_even - CW'(1);
                    end
                end
            end
            OP_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_total   = cnt5(w_held);
                    n_o_even    = cnt5(r_even);
                    n_o_odd     = cnt5(r_odd);
                end
            end
            OP_RREAD, OP_NOP: begin
            end
        endcase

        unique case (w_ctrl.cond)
            C_NEXT:     n_step = r_step + STEP_W'(1);
            C_JUMP:     n_step = w_ctrl.target;
            C_DISPATCH: n_step = w_accept ? mode_entry(i_mode) : r_step;
            C_LEFT0:    n_step = (r_left == 5'd0) ? w_ctrl.target : r_step + STEP_W'(1);
            C_OUTFREE:  n_step = w_out_free ? w_ctrl.target : r_step;
            default:    n_step = SP_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= SP_FETCH;
            r_front     <= '0;
            r_even      <= '0;
            r_odd       <= '0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_front     <= n_front;
            r_even      <= n_even;
            r_odd       <= n_odd;
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status   <= n_status;
        r_par      <= n_par;
        r_ne       <= n_ne;
        r_no       <= n_no;
        r_nr       <= n_nr;
        r_left     <= n_left;
        r_o_status <= n_o_status;
        r_o_total  <= n_o_total;
        r_o_even   <= n_o_even;
        r_o_odd    <= n_o_odd;
    end

    // Tag store: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tags[w_waddr] <= w_wdata;
        end
        if (w_ctrl.op == OP_RREAD) begin
            r_ftag <= r_tags[r_front];
            r_btag <= r_tags[w_back_slot];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_o_status;
    assign o_total_held = r_o_total;
    assign o_evens_held = r_o_even;
    assign o_odds_held  = r_o_odd;

endmodule

// ----- src/psdq_checker.sv -----
`include "parity_steered_deque_assert.svh"

module psdq_checker
    import psdq_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [1:0]         i_mode,
    input logic signed [31:0] i_value,
    input logic [4:0]         i_even_pops,
    input logic [4:0]         i_odd_pops,
    input logic [4:0]         i_recent_pops,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_status,
    input logic [4:0]         o_total_held,
    input logic [4:0]         o_evens_held,
    input logic [4:0]         o_odds_held
);

    // A result that is not taken stays in place.
    `PSDQ_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) && $stable(o_total_held), "stalled result changed")

    // The total always splits into the even and odd counts.
    `PSDQ_ASSERT(a_count_sum, i_clk, i_rst_n, o_out_valid |-> o_total_held == 5'(o_evens_held + o_odds_held), "total differs from even plus odd")

    // After an item is accepted the sequencer leaves its fetch step, so input closes.
    `PSDQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "item accepted while busy")

    // A status of three is never produced.
    `PSDQ_ASSERT(a_status_code, i_clk, i_rst_n, o_out_valid |-> o_status == ST_DONE || o_status == ST_FULL || o_status == ST_SHORT, "unknown status")

    // Reset empties the output register.
    `PSDQ_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid, "result present after reset")

endmodule

bind parity_steered_deque psdq_checker u_psdq_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import psdq_pkg::*;

    localparam int DEPTH = 16;

    // All block inputs start at known values before the first clock edge.
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic [1:0]         i_mode = MODE_NONE;
    logic signed [31:0] i_value = '0;
    logic [4:0]         i_even_pops = '0;
    logic [4:0]         i_odd_pops = '0;
    logic [4:0]         i_recent_pops = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [1:0]         o_status;
    logic [4:0]         o_total_held;
    logic [4:0]         o_evens_held;
    logic [4:0]         o_odds_held;

    // One result item as the block reports it.
    typedef struct {
        logic [1:0] status;
        logic [4:0] total;
        logic [4:0] evens;
        logic [4:0] odds;
    } t_held_counts;

    // Shadow copy of the deque. Every accepted item is applied here at once,
    // and the counts it should produce are queued until the block reports them.
    class deque_tracker;
        logic [31:0]  slot_val [DEPTH];
        logic [31:0]  slot_tag [DEPTH];
        int           head;
        int           n_even;
        int           n_odd;
        logic [31:0]  tag_seq;
        t_held_counts owed [$];
        int           errors;
        int           n_checked;
        int           n_pushed;
        int           n_full;
        int           n_short;

        function new();
            head = 0;
            n_even = 0;
            n_odd = 0;
            tag_seq = '0;
            errors = 0;
            n_checked = 0;
            n_pushed = 0;
            n_full = 0;
            n_short = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void take_item(logic [1:0] mode, logic [31:0] value,
                                logic [4:0] ne, logic [4:0] no, logic [4:0] nr);
            t_held_counts r;
            int held;
            int slot;
            int fslot;
            int bslot;
            logic [31:0] gone;
            r.status = ST_DONE;
            held = n_even + n_odd;
            case (mode)
                MODE_PUSH: begin
                    if (held >= DEPTH) begin
                        r.status = ST_FULL;
                        n_full++;
                    end else begin
                        tag_seq = tag_seq + 1;
                        if (!value[0]) begin
                            head = (head + DEPTH - 1) % DEPTH;
                            slot = head;
                            n_even++;
                        end else begin
                            slot = (head + held) % DEPTH;
                            n_odd++;
                        end
                        slot_val[slot] = value;
                        slot_tag[slot] = tag_seq;
                        n_pushed++;
                    end
                end
                MODE_PARITY: begin
                    if (ne > n_even || no > n_odd) begin
                        r.status = ST_SHORT;
                        n_short++;
                    end else begin
                        head = (head + ne) % DEPTH;
                        n_even -= ne;
                        n_odd -= no;
                    end
                end
                MODE_RECENT: begin
                    if (nr > held) begin
                        r.status = ST_SHORT;
                        n_short++;
                    end else begin
                        // The newest entry is at whichever end holds the larger tag.
                        repeat (nr) begin
                            held = n_even + n_odd;
                            fslot = head;
                            bslot = (head + held - 1) % DEPTH;
                            if (held == 1 || slot_tag[fslot] > slot_tag[bslot]) begin
                                gone = slot_val[fslot];
                                head = (head + 1) % DEPTH;
                            end else begin
                                gone = slot_val[bslot];
                            end
                            if (!gone[0]) n_even--;
                            else n_odd--;
                        end
                    end
                end
                default: ;
            endcase
            r.total = 5'(n_even + n_odd);
            r.evens = 5'(n_even);
            r.odds = 5'(n_odd);
            owed.push_back(r);
        endfunction

        function void match_result(logic [1:0] status, logic [4:0] total,
                                   logic [4:0] evens, logic [4:0] odds);
            t_held_counts e;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing owed: status %0d counts %0d/%0d/%0d",
                             $realtime, status, total, evens, odds);
                return;
            end
            e = owed.pop_front();
            n_checked++;
            if (status !== e.status || total !== e.total ||
                evens !== e.evens || odds !== e.odds) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch on result %0d: expected status %0d total %0d %s",
                             $realtime, n_checked, e.status, e.total, "and");
                    $display("    evens %0d odds %0d, got %0d %0d %0d %0d",
                             e.evens, e.odds, status, total, evens, odds);
                end
            end
        endfunction
    endclass

    deque_tracker trk = new();

    // Idling is switched per stretch of the random part; calm turns it off
    // entirely for the tail of the run.
    bit idle_on = 1'b1;
    bit calm = 1'b0;
    int stall_left = 0;

    parity_steered_deque #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_mode(i_mode),
        .i_value(i_value),
        .i_even_pops(i_even_pops),
        .i_odd_pops(i_odd_pops),
        .i_recent_pops(i_recent_pops),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_status(o_status),
        .o_total_held(o_total_held),
        .o_evens_held(o_evens_held),
        .o_odds_held(o_odds_held)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls in random bursts. Stall changes only
    // on the falling edge, so it is steady at each rising edge.
    always @(negedge i_clk) begin
        if (!idle_on || calm) begin
            i_out_stall = 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_out_stall = 1'b1;
            stall_left--;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall = 1'b1;
            stall_left = $urandom_range(0, 3);
        end else begin
            i_out_stall = 1'b0;
        end
    end

    // Every result taken by the receiver is checked against the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            trk.match_result(o_status, o_total_held, o_evens_held, o_odds_held);
    end

    // Offer one item and hold it until the block takes it. An optional burst of
    // idle cycles goes first. The item is applied to the shadow deque at the
    // edge where it is accepted.
    task automatic drive_op(logic [1:0] mode, logic [31:0] value,
                            logic [4:0] ne, logic [4:0] no, logic [4:0] nr);
        int gap;
        if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 4);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_mode = mode;
        i_value = value;
        i_even_pops = ne;
        i_odd_pops = no;
        i_recent_pops = nr;
        do @(posedge i_clk); while (o_in_stall);
        trk.take_item(mode, value, ne, no, nr);
    endtask

    initial begin
        int k;
        int pick;
        int push_bias;
        logic [1:0] mode;
        logic [31:0] value;
        logic [4:0] ne;
        logic [4:0] no;
        logic [4:0] nr;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. On the empty deque: zero-count pops succeed, any
        // nonzero pop is refused.
        drive_op(MODE_RECENT, 32'h0, 5'd0, 5'd0, 5'd0);
        drive_op(MODE_RECENT, 32'h0, 5'd0, 5'd0, 5'd1);
        drive_op(MODE_PARITY, 32'h0, 5'd0, 5'd0, 5'd0);
        drive_op(MODE_PARITY, 32'h0, 5'd0, 5'd1, 5'd0);
        // Extreme values, negative ones included: the low bit alone picks the end.
        drive_op(MODE_PUSH, 32'h0000_0000, 5'd0, 5'd0, 5'd0);
        drive_op(MODE_PUSH, 32'hFFFF_FFFF, 5'd0, 5'd0, 5'd0);
        drive_op(MODE_PUSH, 32'h8000_0000, 5'd0, 5'd0, 5'd0);
        drive_op(MODE_PUSH, 32'h7FFF_FFFF, 5'd0, 5'd0, 5'd0);
        drive_op(MODE_PUSH, 32'hFFFF_FFFE, 5'd0, 5'd0, 5'd0);
        // The newest entry is an even one at the front; the even count must drop.
        drive_op(MODE_RECENT, 32'h0, 5'd0, 5'd0, 5'd1);
        drive_op(MODE_PARITY, 32'h0, 5'd1, 5'd1, 5'd0);
        // Counts at the top of their range are refused.
        drive_op(MODE_PARITY, 32'h0, 5'd31, 5'd31, 5'd31);
        // Fill to the limit with alternating parity, then push once more.
        for (k = 0; k < DEPTH - 2; k++)
            drive_op(MODE_PUSH, {31'($urandom_range(0, 32'h7FFF_FFFF)), k[0]},
                     5'd0, 5'd0, 5'd0);
        drive_op(MODE_PUSH, 32'h1234_5677, 5'd0, 5'd0, 5'd0);
        // The unused mode leaves a full deque alone whatever the other fields say.
        drive_op(MODE_NONE, 32'hFFFF_FFFF, 5'd31, 5'd31, 5'd31);
        // Empty it by recency; the last removal finds a lone entry.
        drive_op(MODE_RECENT, 32'h0, 5'd0, 5'd0, 5'(DEPTH));

        // Random part. The push bias changes per stretch so the deque swings
        // between empty and full. Pop counts mostly fit what is held, so most
        // pops really remove entries; fields the operation ignores stay random.
        push_bias = 50;
        for (k = 0; k < 1750; k++) begin
            if (k % 125 == 0) begin
                push_bias = $urandom_range(20, 80);
                idle_on = ($urandom_range(0, 3) != 0);
            end
            if (k >= 1500) calm = 1'b1;

            value = $urandom;
            case ($urandom_range(0, 15))
                0: value = 32'h8000_0000;
                1: value = 32'h7FFF_FFFF;
                2: value = 32'hFFFF_FFFF;
                3: value = 32'h0000_0000;
                default: ;
            endcase
            ne = 5'($urandom_range(0, 31));
            no = 5'($urandom_range(0, 31));
            nr = 5'($urandom_range(0, 31));

            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                mode = MODE_NONE;
            end else if (pick < 6) begin
                mode = 2'($urandom_range(0, 3));
            end else if ($urandom_range(0, 99) < push_bias) begin
                mode = MODE_PUSH;
            end else if ($urandom_range(0, 1) == 0) begin
                mode = MODE_PARITY;
                if ($urandom_range(0, 9) != 0) begin
                    ne = 5'($urandom_range(0, trk.n_even));
                    no = 5'($urandom_range(0, trk.n_odd));
                end else if ($urandom_range(0, 1) == 0) begin
                    ne = 5'($urandom_range(0, DEPTH));
                    no = 5'($urandom_range(0, DEPTH));
                end
            end else begin
                mode = MODE_RECENT;
                if ($urandom_range(0, 9) != 0)
                    nr = 5'($urandom_range(0, trk.n_even + trk.n_odd));
                else if ($urandom_range(0, 1) == 0)
                    nr = 5'($urandom_range(0, DEPTH));
            end
            drive_op(mode, value, ne, no, nr);
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;

        // Wait for every owed result, then a little longer to catch strays.
        while (trk.pending() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Checked %0d results: %0d pushes stored, %0d refused as full, %0d pops refused.",
                 trk.n_checked, trk.n_pushed, trk.n_full, trk.n_short);
        $display("Mismatches: %0d.", trk.errors);
        if (trk.errors == 0 && trk.pending() == 0) begin
            $display("** parity_steered_deque: PASSED **");
        end else begin
            $display("** parity_steered_deque: FAILED **");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5_000_000;
        $display("Timed out with %0d results still owed.", trk.pending());
        $display("** parity_steered_deque: FAILED **");
        $finish;
    end

endmodule
